// ===== rtl/core/ppal_pkg.sv =====
// Shared types, widths and codes for the programmed PWM angle lookup.
package ppal_pkg;

	// Field widths of the item, result and configuration beats.
	localparam int REQ_W          = 2;
	localparam int MOD_W          = 16;
	localparam int PHASE_W        = 16;
	localparam int BLOCK_SEL_W    = 8;
	localparam int ENTRY_SEL_W    = 5;
	localparam int ANGLE_W        = 15;
	localparam int LEVEL_W        = 4;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 3;
	localparam int BLOCK_COUNT_W  = 9;
	localparam int SWITCH_COUNT_W = 6;

	// Fixed-point scaling of the lookup.
	localparam int QUARTER_SCALE_BITS = 14;
	localparam int PICK_SHIFT         = 20;
	localparam int PRODUCT_W          = 2 * MOD_W;
	localparam int IDX_W              = PRODUCT_W - PICK_SHIFT;

	// Default sizes handed to the top level.
	localparam int BLOCK_DEPTH_DEF  = 256;
	localparam int MAX_SWITCHES_DEF = 32;
	localparam int PHASE_BITS_DEF   = 16;

	// Register reset values.
	localparam logic [MOD_W-1:0]          MIN_MOD_RST   = '0;
	localparam logic [MOD_W-1:0]          BPU_RST       = 16'd64;
	localparam logic [BLOCK_COUNT_W-1:0]  BLK_CNT_RST   = '0;
	localparam logic [SWITCH_COUNT_W-1:0] SW_CNT_RST    = '0;
	localparam logic [LEVEL_W-1:0]        CEILING_RST   = 4'd2;

	// Request codes carried by req_type; the fourth code is ignored.
	typedef enum logic [REQ_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_ENTRY  = 2'd1,
		REQ_START  = 2'd2
	} req_code_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MIN_MOD   = 3'd0,
		CFG_BPU       = 3'd1,
		CFG_BLK_COUNT = 3'd2,
		CFG_SW_COUNT  = 3'd3,
		CFG_CEILING   = 3'd4
	} cfg_index_t;

	// Sequencer states of the lookup engine.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_START,
		ST_LEVEL,
		ST_WALK,
		ST_FINISH
	} eng_state_t;

	// One word of the switching-entry memory.
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [ANGLE_W-1:0] angle;
	} angle_word_t;

	// Status from the block picker to the engine.
	typedef struct packed {
		logic done;
		logic empty;
	} pick_status_t;

	// Result beat from the engine to the output register.
	typedef struct packed {
		logic               valid;
		logic [LEVEL_W-1:0] level;
	} eng_result_t;

endpackage

// ===== rtl/core/programmed_pwm_angle_lookup.sv =====
// Top level of the programmed PWM switching-angle lookup.
// Each item is either a table write or a sample lookup. A table write (entry or
// block start level) is written in its accept cycle and gives no result. A
// sample takes its block through a three-stage pick pipeline, reads the block's
// start level, then walks the block's switching entries one per cycle out of
// the entry memory, stopping at the first entry above the folded phase angle.
// At most MAX_SWITCHES entries are walked, through the single read port of the
// entry memory; with no blocks loaded the start-level read and walk are skipped.
// One item is processed at a time; the next item is taken as soon as the result
// sits in the output register. The user must write configuration only while no
// item is in work; the block itself does not enforce it.
module programmed_pwm_angle_lookup #(
	parameter int BLOCK_DEPTH  = ppal_pkg::BLOCK_DEPTH_DEF,
	parameter int MAX_SWITCHES = ppal_pkg::MAX_SWITCHES_DEF,
	parameter int PHASE_BITS   = ppal_pkg::PHASE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_write,
	input  logic [ppal_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ppal_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Item channel.
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [ppal_pkg::REQ_W-1:0]         req_type,
	input  logic [ppal_pkg::MOD_W-1:0]         modulation,
	input  logic [ppal_pkg::PHASE_W-1:0]       phase,
	input  logic [ppal_pkg::BLOCK_SEL_W-1:0]   block_sel,
	input  logic [ppal_pkg::ENTRY_SEL_W-1:0]   entry_sel,
	input  logic [ppal_pkg::ANGLE_W-1:0]       entry_angle,
	input  logic [ppal_pkg::LEVEL_W-1:0]       entry_level,
	// Result channel.
	output logic                               level_valid,
	input  logic                               level_stall,
	output logic [ppal_pkg::LEVEL_W-1:0]       pwm_level
);
	import ppal_pkg::*;

	localparam int BLK_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;

	logic [MOD_W-1:0]          min_mod_q;
	logic [MOD_W-1:0]          bpu_q;
	logic [BLOCK_COUNT_W-1:0]  blk_cnt_q;
	logic [SWITCH_COUNT_W-1:0] sw_cnt_q;
	logic [LEVEL_W-1:0]        ceiling_q;

	logic               level_valid_q;
	logic [LEVEL_W-1:0] pwm_level_q;

	logic               eng_idle;
	logic               accept;
	logic               out_free;
	logic [BLK_W-1:0]   pick_blk;
	pick_status_t       pick_st;
	eng_result_t        res;

	// Item handshake; the output register frees once its beat is taken.
	assign item_stall = !eng_idle;
	assign accept     = item_valid && !item_stall;
	assign out_free   = !level_valid_q || !level_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mod_q <= MIN_MOD_RST;
			bpu_q     <= BPU_RST;
			blk_cnt_q <= BLK_CNT_RST;
			sw_cnt_q  <= SW_CNT_RST;
			ceiling_q <= CEILING_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MIN_MOD:   min_mod_q <= cfg_data;
				CFG_BPU:       bpu_q     <= cfg_data;
				CFG_BLK_COUNT: blk_cnt_q <= cfg_data[BLOCK_COUNT_W-1:0];
				CFG_SW_COUNT:  sw_cnt_q  <= cfg_data[SWITCH_COUNT_W-1:0];
				CFG_CEILING:   ceiling_q <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Block picker.
	ppal_block_pick #(
		.BLOCK_DEPTH (BLOCK_DEPTH),
		.BLK_W       (BLK_W)
	) u_pick (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (accept && (req_type == REQ_SAMPLE)),
		.modulation      (modulation),
		.min_modulation  (min_mod_q),
		.blocks_per_unit (bpu_q),
		.block_count     (blk_cnt_q),
		.blk             (pick_blk),
		.status          (pick_st)
	);

	// Table memories and entry walk.
	ppal_engine #(
		.BLOCK_DEPTH  (BLOCK_DEPTH),
		.MAX_SWITCHES (MAX_SWITCHES),
		.PHASE_BITS   (PHASE_BITS),
		.BLK_W        (BLK_W)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.req_type      (req_type),
		.phase         (phase),
		.block_sel     (block_sel),
		.entry_sel     (entry_sel),
		.entry_angle   (entry_angle),
		.entry_level   (entry_level),
		.pick_blk      (pick_blk),
		.pick_st       (pick_st),
		.switch_count  (sw_cnt_q),
		.level_ceiling (ceiling_q),
		.out_free      (out_free),
		.idle          (eng_idle),
		.res           (res)
	);

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_valid_q <= 1'b0;
		end else if (res.valid) begin
			level_valid_q <= 1'b1;
		end else if (!level_stall) begin
			level_valid_q <= 1'b0;
		end
	end

	// Output register: payload.
	always_ff @(posedge clk) begin
		if (res.valid) begin
			pwm_level_q <= res.level;
		end
	end

	assign level_valid = level_valid_q;
	assign pwm_level   = pwm_level_q;

endmodule

// ===== rtl/core/ppal_block_pick.sv =====
// Three-stage pipeline that maps a modulation index to a table block.
module ppal_block_pick #(
	parameter int BLOCK_DEPTH = ppal_pkg::BLOCK_DEPTH_DEF,
	parameter int BLK_W       = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ppal_pkg::MOD_W-1:0]          modulation,
	input  logic [ppal_pkg::MOD_W-1:0]          min_modulation,
	input  logic [ppal_pkg::MOD_W-1:0]          blocks_per_unit,
	input  logic [ppal_pkg::BLOCK_COUNT_W-1:0]  block_count,
	output logic [BLK_W-1:0]                    blk,
	output ppal_pkg::pick_status_t              status
);
	import ppal_pkg::*;

	localparam logic [IDX_W-1:0] DEPTH_M1 = IDX_W'(BLOCK_DEPTH - 1);

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 empty_s1, empty_s2, empty_s3;
	logic [MOD_W-1:0]     diff_s1;
	logic [IDX_W-1:0]     limit_s1, limit_s2;
	logic [PRODUCT_W-1:0] prod_s2;
	logic [BLK_W-1:0]     blk_s3;
	logic [IDX_W-1:0]     cnt_m1;
	logic [IDX_W-1:0]     idx;

	// Last usable block is one below the smaller of the loaded count and the depth.
	assign cnt_m1 = IDX_W'(block_count - BLOCK_COUNT_W'(1));
	assign idx    = prod_s2[PRODUCT_W-1:PICK_SHIFT];

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: offset from the lowest modulation, and the clamp limit.
	always_ff @(posedge clk) begin
		if (start) begin
			diff_s1  <= (modulation > min_modulation) ? modulation - min_modulation : '0;
			empty_s1 <= (block_count == '0);
			limit_s1 <= (cnt_m1 < DEPTH_M1) ? cnt_m1 : DEPTH_M1;
		end
	end

	// Stage 2: scale the offset by the blocks-per-unit factor.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2  <= PRODUCT_W'(diff_s1) * PRODUCT_W'(blocks_per_unit);
			empty_s2 <= empty_s1;
			limit_s2 <= limit_s1;
		end
	end

	// Stage 3: truncate and clamp to the loaded range.
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			blk_s3   <= BLK_W'((idx < limit_s2) ? idx : limit_s2);
			empty_s3 <= empty_s2;
		end
	end

	assign blk          = blk_s3;
	assign status.done  = valid_s3;
	assign status.empty = empty_s3;

endmodule

// ===== rtl/core/ppal_engine.sv =====
// Table memories and the sequencer that walks one block's switching entries.
module ppal_engine #(
	parameter int BLOCK_DEPTH  = ppal_pkg::BLOCK_DEPTH_DEF,
	parameter int MAX_SWITCHES = ppal_pkg::MAX_SWITCHES_DEF,
	parameter int PHASE_BITS   = ppal_pkg::PHASE_BITS_DEF,
	parameter int BLK_W        = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [ppal_pkg::REQ_W-1:0]           req_type,
	input  logic [ppal_pkg::PHASE_W-1:0]         phase,
	input  logic [ppal_pkg::BLOCK_SEL_W-1:0]     block_sel,
	input  logic [ppal_pkg::ENTRY_SEL_W-1:0]     entry_sel,
	input  logic [ppal_pkg::ANGLE_W-1:0]         entry_angle,
	input  logic [ppal_pkg::LEVEL_W-1:0]         entry_level,
	input  logic [BLK_W-1:0]                     pick_blk,
	input  ppal_pkg::pick_status_t               pick_st,
	input  logic [ppal_pkg::SWITCH_COUNT_W-1:0]  switch_count,
	input  logic [ppal_pkg::LEVEL_W-1:0]         level_ceiling,
	input  logic                                 out_free,
	output logic                                 idle,
	output ppal_pkg::eng_result_t                res
);
	import ppal_pkg::*;

	localparam int ENTRIES = BLOCK_DEPTH * MAX_SWITCHES;
	localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(MAX_SWITCHES + 1);
	localparam int FOLD_W  = PHASE_BITS - 1;
	localparam int FRAC_W  = PHASE_BITS - 2;
	localparam int CMP_W   = ANGLE_W + FRAC_W;
	localparam logic [FOLD_W-1:0] QUARTER = FOLD_W'(1) << FRAC_W;

	// Entry and start-level memories.
	angle_word_t        angle_mem [ENTRIES];
	logic [LEVEL_W-1:0] start_mem [BLOCK_DEPTH];

	eng_state_t         state_q, state_d;
	angle_word_t        angle_rd_q;
	logic [LEVEL_W-1:0] start_rd_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CNT_W-1:0]   j_q, walk_q, walk;
	logic [FOLD_W-1:0]  folded_q, folded;
	logic [1:0]         quad_q;
	logic [LEVEL_W-1:0] level_q;
	logic               empty_q;

	logic [PHASE_BITS-1:0] phase_m;
	logic [1:0]            quad;
	logic [FRAC_W-1:0]     frac;
	logic [CMP_W-1:0]      lhs, rhs;
	logic                  hit, more;
	logic                  is_sample;
	logic                  angle_we, start_we;
	logic [ADDR_W-1:0]     angle_waddr;
	logic                  angle_re, start_re;
	logic [ADDR_W-1:0]     angle_raddr;
	logic [ADDR_W-1:0]     base;
	logic [LEVEL_W-1:0]    inverted;

	// Phase folding into one quarter turn.
	assign phase_m = PHASE_BITS'(phase);
	assign quad    = phase_m[PHASE_BITS-1 -: 2];
	assign frac    = phase_m[FRAC_W-1:0];
	assign folded  = quad[0] ? QUARTER - FOLD_W'(frac) : FOLD_W'(frac);

	// Entry angle against folded phase, both brought to a common scale.
	assign lhs  = CMP_W'(angle_rd_q.angle) << FRAC_W;
	assign rhs  = CMP_W'(folded_q) << QUARTER_SCALE_BITS;
	assign hit  = (lhs <= rhs);
	assign more = ((j_q + CNT_W'(1)) < walk_q);

	// Entries walked per block.
	assign walk = (32'(switch_count) > MAX_SWITCHES) ? CNT_W'(MAX_SWITCHES)
	                                                 : CNT_W'(switch_count);
	assign base = ADDR_W'(32'(pick_blk) * MAX_SWITCHES);

	// Table writes are taken in the accept cycle; out-of-range writes drop.
	assign is_sample   = accept && (req_type == REQ_SAMPLE);
	assign angle_we    = accept && (req_type == REQ_ENTRY) &&
	                     (32'(block_sel) < BLOCK_DEPTH) && (32'(entry_sel) < MAX_SWITCHES);
	assign start_we    = accept && (req_type == REQ_START) && (32'(block_sel) < BLOCK_DEPTH);
	assign angle_waddr = ADDR_W'(32'(block_sel) * MAX_SWITCHES + 32'(entry_sel));

	// Second half-turn inversion against the ceiling, saturating at zero.
	assign inverted = (level_ceiling >= level_q) ? level_ceiling - level_q : '0;

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (angle_we) begin
			angle_mem[angle_waddr] <= '{level: entry_level, angle: entry_angle};
		end
		if (angle_re) begin
			angle_rd_q <= angle_mem[angle_raddr];
		end
	end

	// Start-level memory.
	always_ff @(posedge clk) begin
		if (start_we) begin
			start_mem[BLK_W'(block_sel)] <= entry_level;
		end
		if (start_re) begin
			start_rd_q <= start_mem[pick_blk];
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (is_sample) state_d = ST_PICK;
			ST_PICK:   if (pick_st.done) state_d = pick_st.empty ? ST_FINISH : ST_START;
			ST_START:  state_d = ST_LEVEL;
			ST_LEVEL:  state_d = (walk_q == '0) ? ST_FINISH : ST_WALK;
			ST_WALK:   if (!(hit && more)) state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory reads and the result beat.
	always_comb begin
		idle        = 1'b0;
		start_re    = 1'b0;
		angle_re    = 1'b0;
		angle_raddr = addr_q;
		res.valid   = 1'b0;
		res.level   = empty_q ? '0 : (quad_q[1] ? inverted : level_q);
		case (state_q)
			ST_IDLE:   idle = 1'b1;
			ST_START:  start_re = 1'b1;
			ST_LEVEL:  angle_re = (walk_q != '0);
			ST_WALK: begin
				angle_re    = hit && more;
				angle_raddr = addr_q + ADDR_W'(1);
			end
			ST_FINISH: res.valid = out_free;
			default: ;
		endcase
	end

	// Datapath registers of the walk.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (is_sample) begin
					folded_q <= folded;
					quad_q   <= quad;
				end
			end
			ST_PICK: begin
				if (pick_st.done) begin
					empty_q <= pick_st.empty;
				end
			end
			ST_START: begin
				addr_q <= base;
				walk_q <= walk;
			end
			ST_LEVEL: begin
				level_q <= start_rd_q;
				j_q     <= '0;
			end
			ST_WALK: begin
				if (hit) begin
					level_q <= angle_rd_q.level;
					if (more) begin
						addr_q <= addr_q + ADDR_W'(1);
						j_q    <= j_q + CNT_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/sv/tb_programmed_pwm_angle_lookup.sv =====
// Self-checking testbench for the programmed PWM angle lookup, predicting every result beat.
`timescale 1ns / 100ps
module tb_programmed_pwm_angle_lookup;
	import ppal_pkg::*;

	localparam int TABLE_BLOCKS    = BLOCK_DEPTH_DEF;
	localparam int TABLE_ENTRIES   = MAX_SWITCHES_DEF;
	localparam int LOADED_BLOCKS   = 16;
	localparam int FRAC_W          = PHASE_BITS_DEF - 2;
	localparam int QUARTER_TURN    = 1 << FRAC_W;
	localparam int ANGLE_STOP      = (1 << ANGLE_W) - 1;
	localparam int MOD_MAX         = (1 << MOD_W) - 1;
	localparam int SETTLE_CYCLES   = 50;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_CYCLES     = 400;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 110;

	// The fourth request code carries no meaning and must be dropped by the block.
	localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

	// One beat of the item channel.
	typedef struct {
		logic [REQ_W-1:0]       req;
		logic [MOD_W-1:0]       modulation;
		logic [PHASE_W-1:0]     phase;
		logic [BLOCK_SEL_W-1:0] block_sel;
		logic [ENTRY_SEL_W-1:0] entry_sel;
		logic [ANGLE_W-1:0]     angle;
		logic [LEVEL_W-1:0]     level;
	} table_item_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_write;
	logic [CFG_INDEX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      item_valid;
	logic                      item_stall;
	logic [REQ_W-1:0]          req_type;
	logic [MOD_W-1:0]          modulation;
	logic [PHASE_W-1:0]        phase;
	logic [BLOCK_SEL_W-1:0]    block_sel;
	logic [ENTRY_SEL_W-1:0]    entry_sel;
	logic [ANGLE_W-1:0]        entry_angle;
	logic [LEVEL_W-1:0]        entry_level;
	logic                      level_valid;
	logic                      level_stall;
	logic [LEVEL_W-1:0]        pwm_level;

	// Mirror of the switching table and the registers, updated as beats are accepted.
	angle_word_t               table_words [TABLE_BLOCKS][TABLE_ENTRIES];
	logic [LEVEL_W-1:0]        start_levels [TABLE_BLOCKS];
	logic [MOD_W-1:0]          min_mod_reg      = MIN_MOD_RST;
	logic [MOD_W-1:0]          bpu_reg          = BPU_RST;
	logic [BLOCK_COUNT_W-1:0]  block_count_reg  = BLK_CNT_RST;
	logic [SWITCH_COUNT_W-1:0] switch_count_reg = SW_CNT_RST;
	logic [LEVEL_W-1:0]        ceiling_reg      = CEILING_RST;

	logic [LEVEL_W-1:0]        level_expect_q [$];
	int                        fail_count     = 0;
	int                        send_idle_pct  = 0;
	int                        recv_stall_pct = 0;
	int                        hold_left      = 0;
	int                        idle_cycles    = 0;

	programmed_pwm_angle_lookup u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.req_type    (req_type),
		.modulation  (modulation),
		.phase       (phase),
		.block_sel   (block_sel),
		.entry_sel   (entry_sel),
		.entry_angle (entry_angle),
		.entry_level (entry_level),
		.level_valid (level_valid),
		.level_stall (level_stall),
		.pwm_level   (pwm_level)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Number of blocks a sample may land in.
	function automatic int usable_blocks();
		return (block_count_reg > TABLE_BLOCKS) ? TABLE_BLOCKS : int'(block_count_reg);
	endfunction

	// Block chosen by a modulation index, clamped to the loaded range.
	function automatic int pick_block(logic [MOD_W-1:0] mod);
		logic [MOD_W-1:0]     diff;
		logic [PRODUCT_W-1:0] prod;
		int                   blk;
		if (mod <= min_mod_reg || usable_blocks() == 0) return 0;
		diff = mod - min_mod_reg;
		prod = PRODUCT_W'(diff) * PRODUCT_W'(bpu_reg);
		blk = int'(prod >> PICK_SHIFT);
		if (blk > usable_blocks() - 1) blk = usable_blocks() - 1;
		return blk;
	endfunction

	// Gate level for one sample: fold the phase, walk the entries, invert in the second half.
	function automatic logic [LEVEL_W-1:0] predict_level(logic [MOD_W-1:0] mod,
			logic [PHASE_W-1:0] ph);
		int                 blk;
		int                 walk;
		int                 folded;
		logic [1:0]         quad;
		logic [LEVEL_W-1:0] lvl;
		if (usable_blocks() == 0) return '0;
		blk = pick_block(mod);
		quad = ph[PHASE_W-1 -: 2];
		folded = quad[0] ? QUARTER_TURN - int'(ph[FRAC_W-1:0]) : int'(ph[FRAC_W-1:0]);
		walk = (switch_count_reg > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(switch_count_reg);
		lvl = start_levels[blk];
		for (int j = 0; j < walk; j++) begin
			if (int'(table_words[blk][j].angle) > folded) break;
			lvl = table_words[blk][j].level;
		end
		if (quad[1]) lvl = (ceiling_reg >= lvl) ? ceiling_reg - lvl : '0;
		return lvl;
	endfunction

	// Apply one accepted beat to the mirror, queueing the level a sample must produce.
	function automatic void apply_item(table_item_t it);
		case (it.req)
			REQ_SAMPLE: level_expect_q.push_back(predict_level(it.modulation, it.phase));
			REQ_ENTRY:  table_words[it.block_sel][it.entry_sel] = {it.level, it.angle};
			REQ_START:  start_levels[it.block_sel] = it.level;
			default: ;
		endcase
	endfunction

	function automatic table_item_t random_item();
		table_item_t it;
		it.req        = REQ_SAMPLE;
		it.modulation = MOD_W'($urandom);
		it.phase      = PHASE_W'($urandom);
		it.block_sel  = BLOCK_SEL_W'($urandom);
		it.entry_sel  = ENTRY_SEL_W'($urandom);
		it.angle      = ANGLE_W'($urandom);
		it.level      = LEVEL_W'($urandom);
		return it;
	endfunction

	// Mostly samples, some aimed exactly at a stored angle; entry writes mostly keep order.
	function automatic table_item_t pick_traffic_item();
		table_item_t it;
		int          roll;
		int          blk;
		int          a;
		int          lo;
		int          hi;
		int          e;
		logic [1:0]  q;
		it = random_item();
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			if ($urandom_range(0, 3) == 0)
				it.modulation = min_mod_reg + MOD_W'($urandom_range(0, 4096));
			if ($urandom_range(0, 9) < 3) begin
				blk = pick_block(it.modulation);
				a = table_words[blk][$urandom_range(0, TABLE_ENTRIES - 1)].angle;
				q = 2'($urandom);
				if (q[0] && a >= 1 && a <= QUARTER_TURN)
					it.phase = {q, FRAC_W'(QUARTER_TURN - a)};
				else if (!q[0] && a < QUARTER_TURN)
					it.phase = {q, FRAC_W'(a)};
			end
		end else if (roll < 88) begin
			it.req = REQ_ENTRY;
			if ($urandom_range(0, 9) < 7 && usable_blocks() > 0)
				it.block_sel = BLOCK_SEL_W'($urandom_range(0, usable_blocks() - 1));
			e = it.entry_sel;
			lo = (e == 0) ? 0 : int'(table_words[it.block_sel][e - 1].angle);
			hi = (e == TABLE_ENTRIES - 1) ? QUARTER_TURN
				: int'(table_words[it.block_sel][e + 1].angle);
			if (hi > QUARTER_TURN) hi = QUARTER_TURN;
			if ($urandom_range(0, 9) < 8 && lo <= hi)
				it.angle = ANGLE_W'($urandom_range(lo, hi));
		end else if (roll < 97) begin
			it.req = REQ_START;
			if ($urandom_range(0, 9) < 7 && usable_blocks() > 0)
				it.block_sel = BLOCK_SEL_W'($urandom_range(0, usable_blocks() - 1));
		end else begin
			it.req = REQ_IGNORED;
		end
		return it;
	endfunction

	// Offer one beat after a random gap and hold it until the block takes it.
	task automatic send_item(table_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid  = 1'b1;
		req_type    = it.req;
		modulation  = it.modulation;
		phase       = it.phase;
		block_sel   = it.block_sel;
		entry_sel   = it.entry_sel;
		entry_angle = it.angle;
		entry_level = it.level;
		do @(posedge clk); while (item_stall);
		apply_item(it);
	endtask

	task automatic send_sample(int mod, int ph);
		table_item_t it;
		it = random_item();
		it.modulation = MOD_W'(mod);
		it.phase = PHASE_W'(ph);
		send_item(it);
	endtask

	task automatic send_entry(int blk, int ent, int ang, int lvl);
		table_item_t it;
		it = random_item();
		it.req       = REQ_ENTRY;
		it.block_sel = BLOCK_SEL_W'(blk);
		it.entry_sel = ENTRY_SEL_W'(ent);
		it.angle     = ANGLE_W'(ang);
		it.level     = LEVEL_W'(lvl);
		send_item(it);
	endtask

	task automatic send_start(int blk, int lvl);
		table_item_t it;
		it = random_item();
		it.req       = REQ_START;
		it.block_sel = BLOCK_SEL_W'(blk);
		it.level     = LEVEL_W'(lvl);
		send_item(it);
	endtask

	// Drop valid, wait for every outstanding level, then let any write finish.
	task automatic wait_drained();
		@(negedge clk);
		item_valid = 1'b0;
		while (level_expect_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(cfg_index_t idx, int value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = CFG_DATA_W'(value);
		case (idx)
			CFG_MIN_MOD:   min_mod_reg      = MOD_W'(value);
			CFG_BPU:       bpu_reg          = MOD_W'(value);
			CFG_BLK_COUNT: block_count_reg  = BLOCK_COUNT_W'(value);
			CFG_SW_COUNT:  switch_count_reg = SWITCH_COUNT_W'(value);
			CFG_CEILING:   ceiling_reg      = LEVEL_W'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic set_config(int min_mod, int bpu, int blocks, int switches, int ceiling);
		write_register(CFG_MIN_MOD, min_mod);
		write_register(CFG_BPU, bpu);
		write_register(CFG_BLK_COUNT, blocks);
		write_register(CFG_SW_COUNT, switches);
		write_register(CFG_CEILING, ceiling);
	endtask

	task automatic set_idle(int sender_pct, int receiver_pct);
		send_idle_pct  = sender_pct;
		recv_stall_pct = receiver_pct;
	endtask

	// Load one block: a start level and ascending angles, sometimes closed by unreachable ones.
	task automatic fill_block(int blk);
		int angle;
		bit tail;
		angle = 0;
		tail = 1'b0;
		send_start(blk, $urandom_range(0, 15));
		for (int e = 0; e < TABLE_ENTRIES; e++) begin
			if (!tail && $urandom_range(0, 31) == 0) tail = 1'b1;
			angle += $urandom_range(0, 1100);
			if (angle > QUARTER_TURN) angle = QUARTER_TURN;
			send_entry(blk, e, tail ? ANGLE_STOP : angle, $urandom_range(0, 15));
		end
	endtask

	// With no blocks loaded every sample answers zero, and the table is never read.
	task automatic test_empty_table();
		set_idle(0, 0);
		send_sample(0, 0);
		send_sample(MOD_MAX, 16'hFFFF);
		send_sample(16'h8000, QUARTER_TURN);
	endtask

	// Every entry and start level of the loaded blocks is written before any lookup reaches it.
	task automatic test_table_load();
		set_idle(0, 0);
		for (int b = 0; b < LOADED_BLOCKS; b++) fill_block(b);
	endtask

	// Quadrant edges, exact angle match, saturation, empty walk, block clamping and the ignored code.
	task automatic test_directed_lookup();
		table_item_t it;
		int          phases [8];
		phases = '{0, 99, 100, QUARTER_TURN - 1, QUARTER_TURN, 2 * QUARTER_TURN,
			3 * QUARTER_TURN, 4 * QUARTER_TURN - 1};
		wait_drained();
		set_config(0, 64, LOADED_BLOCKS, TABLE_ENTRIES, 15);
		send_start(0, 9);
		send_entry(0, 0, 0, 3);
		send_entry(0, 1, 100, 5);
		send_entry(0, 2, QUARTER_TURN, 15);
		send_entry(0, 3, ANGLE_STOP, 0);
		foreach (phases[i]) send_sample(0, phases[i]);
		it = random_item();
		it.req = REQ_IGNORED;
		send_item(it);

		// Steepest block step: the first step boundary and clamping to the last block.
		wait_drained();
		set_config(0, MOD_MAX, LOADED_BLOCKS, TABLE_ENTRIES, 15);
		send_sample(16, 100);
		send_sample(17, 100);
		send_sample(MOD_MAX, 16'h1234);

		// Everything at or below the minimum lands in block zero; no entries are walked.
		wait_drained();
		set_config(MOD_MAX, 64, 1, 0, 1);
		send_sample(MOD_MAX, 2 * QUARTER_TURN);
		send_sample(0, 100);

		// Inversion against a low ceiling saturates at zero.
		wait_drained();
		set_config(0, 64, LOADED_BLOCKS, TABLE_ENTRIES, 1);
		send_sample(0, 3 * QUARTER_TURN);
		send_sample(0, 2 * QUARTER_TURN);
	endtask

	// The receiver holds off while beats keep coming, then the sender waits for all levels.
	task automatic test_backpressure();
		wait_drained();
		set_config(0, 1024, LOADED_BLOCKS, TABLE_ENTRIES, 7);
		set_idle(0, 0);
		repeat (8) send_item(pick_traffic_item());
		hold_left = HOLD_CYCLES;
		repeat (40) send_item(pick_traffic_item());
		wait_drained();
		repeat (8) send_item(pick_traffic_item());
	endtask

	// Phases of random traffic, each with its own settings and idling pattern.
	task automatic test_random_traffic();
		int min_mod;
		int bpu;
		int blocks;
		int switches;
		int ceiling;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			case (p % 4)
				0: set_idle(0, 0);
				1: set_idle(58, 0);
				2: set_idle(0, 58);
				default: set_idle(9, 9);
			endcase
			min_mod  = (p == 0) ? 0 : (p == 1) ? MOD_MAX : $urandom_range(0, 8192);
			bpu      = (p == 2) ? 0 : (p == 3) ? MOD_MAX : $urandom_range(64, 4096);
			blocks   = (p == 4) ? LOADED_BLOCKS : (p == 5) ? 1 : (p == 6) ? 0
				: $urandom_range(2, LOADED_BLOCKS);
			switches = (p == 0) ? TABLE_ENTRIES : (p == 1) ? 0
				: $urandom_range(1, TABLE_ENTRIES);
			ceiling  = (p == 7) ? 1 : (p == 3) ? 15 : $urandom_range(1, 15);
			set_config(min_mod, bpu, blocks, switches, ceiling);
			repeat (2) fill_block($urandom_range(0, (blocks > 0) ? blocks - 1 : 0));
			repeat (ITEMS_PER_PHASE) send_item(pick_traffic_item());
		end
	endtask

	// Result side: random stall, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			level_stall = 1'b1;
			hold_left--;
		end else begin
			level_stall = ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Compare each accepted level beat with the oldest prediction.
	always @(posedge clk) begin : check_levels
		logic [LEVEL_W-1:0] want;
		if (arst_n && level_valid && !level_stall) begin
			if (level_expect_q.size() == 0) begin
				$error("pwm_level beat with no sample outstanding: actual %0d", pwm_level);
				fail_count++;
			end else begin
				want = level_expect_q.pop_front();
				if (pwm_level !== want) begin
					$error("pwm_level mismatch: expected %0d, actual %0d", want, pwm_level);
					fail_count++;
				end
			end
		end
	end

	// End the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (level_valid && !level_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("programmed_pwm_angle_lookup test failed");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = CFG_MIN_MOD;
		cfg_data    = '0;
		item_valid  = 1'b0;
		req_type    = REQ_SAMPLE;
		modulation  = '0;
		phase       = '0;
		block_sel   = '0;
		entry_sel   = '0;
		entry_angle = '0;
		entry_level = '0;
		level_stall = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		test_empty_table();
		test_table_load();
		test_directed_lookup();
		test_backpressure();
		test_random_traffic();
		wait_drained();

		if (fail_count == 0 && level_expect_q.size() == 0)
			$display("programmed_pwm_angle_lookup test passed");
		else
			$display("programmed_pwm_angle_lookup test failed");
		$finish;
	end

endmodule
